// ===== sv/rk4s_pkg.sv =====
// Package for the RK4 second-order ODE stepper: widths, types, commands and arithmetic helpers.
package rk4s_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 24;
    localparam int STEP_W    = 25;
    localparam int CNT_W     = 7;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = DATA_W + 4;
    localparam int QUO_W     = DATA_W + 1;
    // divide by 6 as a multiply by (4^18 - 1) / 3 built from shifted adds, then >> 36
    localparam int REC_W     = 70;
    localparam int REC_SH    = 36;
    localparam int DIVC_W    = 3;

    localparam logic [CNT_W-1:0]  MAX_STEPS  = CNT_W'(64);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1677722);
    localparam logic [DIVC_W-1:0] DIV_LAST   = DIVC_W'(4);
    localparam logic [1:0]        STAGE_LAST = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_start;
        logic signed [DATA_W-1:0] y_start;
        logic signed [DATA_W-1:0] slope_start;
        logic [CNT_W-1:0]         step_count;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_now;
        logic signed [DATA_W-1:0] y_value;
        logic signed [DATA_W-1:0] slope_value;
        logic                     last_step;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_MUL_KY, ST_WB_KY, ST_MUL_F, ST_WB_F,
        ST_MUL_KS, ST_WB_KS, ST_UPD, ST_DIV_INIT, ST_DIV, ST_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_PREP, OP_MUL_KY, OP_WB_KY, OP_MUL_F, OP_WB_F,
        OP_MUL_KS, OP_WB_KS, OP_UPD, OP_DIV_INIT, OP_DIV, OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [1:0]          stage;
        logic [DIVC_W-1:0]   div_step;
        logic                last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] sum;
        sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (sum[DATA_W] != sum[DATA_W-1]) begin
            sat_add = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sat_add = sum[DATA_W-1:0];
        end
    endfunction

    // round to nearest (ties up), drop fraction bits, clamp to 32 bits
    function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        logic signed [PROD_W-1:0] sh;
        r  = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
        sh = r >>> FRAC_BITS;
        if (sh > $signed({{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}})) begin
            rnd_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (sh < $signed({{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}})) begin
            rnd_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            rnd_sat = sh[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== sv/rk4s_ctrl.sv =====
// Sequencer for the RK4 stepper: stage, divider and step counting, handshakes.
module rk4s_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rk4s_pkg::CNT_W-1:0] step_count,
    input  logic                       m_ready,
    input  rk4s_pkg::dp_status_t       status,
    output rk4s_pkg::dp_cmd_t          cmd
);

    rk4s_pkg::ctrl_state_t             state_reg, state_next;
    logic [1:0]                        stage_reg, stage_next;
    logic [rk4s_pkg::DIVC_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [rk4s_pkg::CNT_W-1:0]        steps_left_reg, steps_left_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rk4s_pkg::ST_IDLE;
            stage_reg      <= 2'd0;
            div_cnt_reg    <= '0;
            steps_left_reg <= '0;
        end else begin
            state_reg      <= state_next;
            stage_reg      <= stage_next;
            div_cnt_reg    <= div_cnt_next;
            steps_left_reg <= steps_left_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        stage_next      = stage_reg;
        div_cnt_next    = div_cnt_reg;
        steps_left_next = steps_left_reg;
        s_ready         = 1'b0;
        cmd.op          = rk4s_pkg::OP_NONE;
        cmd.stage       = stage_reg;
        cmd.div_step    = div_cnt_reg;
        cmd.last        = (steps_left_reg == rk4s_pkg::CNT_W'(1));
        unique case (state_reg)
            rk4s_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = rk4s_pkg::OP_LOAD;
                    steps_left_next = (step_count > rk4s_pkg::MAX_STEPS) ?
                                      rk4s_pkg::MAX_STEPS : step_count;
                    // a zero count loads the start point and emits nothing
                    state_next = (step_count == '0) ? rk4s_pkg::ST_IDLE : rk4s_pkg::ST_PREP;
                end
            end
            rk4s_pkg::ST_PREP: begin
                cmd.op     = rk4s_pkg::OP_PREP;
                stage_next = 2'd0;
                state_next = rk4s_pkg::ST_MUL_KY;
            end
            rk4s_pkg::ST_MUL_KY: begin
                cmd.op     = rk4s_pkg::OP_MUL_KY;
                state_next = rk4s_pkg::ST_WB_KY;
            end
            rk4s_pkg::ST_WB_KY: begin
                cmd.op     = rk4s_pkg::OP_WB_KY;
                state_next = rk4s_pkg::ST_MUL_F;
            end
            rk4s_pkg::ST_MUL_F: begin
                cmd.op     = rk4s_pkg::OP_MUL_F;
                state_next = rk4s_pkg::ST_WB_F;
            end
            rk4s_pkg::ST_WB_F: begin
                cmd.op     = rk4s_pkg::OP_WB_F;
                state_next = rk4s_pkg::ST_MUL_KS;
            end
            rk4s_pkg::ST_MUL_KS: begin
                cmd.op     = rk4s_pkg::OP_MUL_KS;
                state_next = rk4s_pkg::ST_WB_KS;
            end
            rk4s_pkg::ST_WB_KS: begin
                cmd.op     = rk4s_pkg::OP_WB_KS;
                state_next = rk4s_pkg::ST_UPD;
            end
            rk4s_pkg::ST_UPD: begin
                cmd.op = rk4s_pkg::OP_UPD;
                if (stage_reg == rk4s_pkg::STAGE_LAST) begin
                    state_next = rk4s_pkg::ST_DIV_INIT;
                end else begin
                    stage_next = stage_reg + 2'd1;
                    state_next = rk4s_pkg::ST_MUL_KY;
                end
            end
            rk4s_pkg::ST_DIV_INIT: begin
                cmd.op       = rk4s_pkg::OP_DIV_INIT;
                div_cnt_next = '0;
                state_next   = rk4s_pkg::ST_DIV;
            end
            rk4s_pkg::ST_DIV: begin
                cmd.op = rk4s_pkg::OP_DIV;
                if (div_cnt_reg == rk4s_pkg::DIV_LAST) begin
                    state_next = rk4s_pkg::ST_EMIT;
                end else begin
                    div_cnt_next = div_cnt_reg + rk4s_pkg::DIVC_W'(1);
                end
            end
            rk4s_pkg::ST_EMIT: begin
                // commit only when the output register is free or being drained
                if (!status.out_full || m_ready) begin
                    cmd.op          = rk4s_pkg::OP_COMMIT;
                    steps_left_next = steps_left_reg - rk4s_pkg::CNT_W'(1);
                    state_next      = (steps_left_reg == rk4s_pkg::CNT_W'(1)) ?
                                      rk4s_pkg::ST_IDLE : rk4s_pkg::ST_PREP;
                end
            end
            default: begin
                state_next = rk4s_pkg::ST_IDLE;
            end
        endcase
    end

    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_left_reg <= rk4s_pkg::MAX_STEPS)
        else $error("step counter above limit");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rk4s_pkg::ST_IDLE |-> steps_left_reg == '0)
        else $error("idle with steps pending");

    a_commit_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == rk4s_pkg::OP_COMMIT |-> steps_left_reg != '0)
        else $error("commit without a pending step");

endmodule

// ===== sv/rk4s_dp.sv =====
// Datapath for the RK4 stepper: shared multiplier, stage registers, divide-by-6 lanes, output register.
module rk4s_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [rk4s_pkg::STEP_W-1:0] cfg_data,
    input  rk4s_pkg::in_item_t          s_data,
    input  logic                        m_ready,
    output logic                        m_valid,
    output rk4s_pkg::out_item_t         m_data,
    input  rk4s_pkg::dp_cmd_t           cmd,
    output rk4s_pkg::dp_status_t        status
);

    localparam int DW = rk4s_pkg::DATA_W;
    localparam int AW = rk4s_pkg::ACC_W;
    localparam int QW = rk4s_pkg::QUO_W;
    localparam int RW = rk4s_pkg::REC_W;
    localparam int RS = rk4s_pkg::REC_SH;

    logic [rk4s_pkg::STEP_W-1:0]       h_reg;
    logic signed [DW-1:0]              x_reg, y_reg, s_reg, xm_reg, xe_reg, xc_reg;
    logic signed [DW-1:0]              ty_reg, ts_reg, f_reg, ky_reg, ks_reg;
    logic signed [rk4s_pkg::PROD_W-1:0] prod_reg;
    logic signed [AW-1:0]              acc_y_reg, acc_s_reg;
    logic [RW-1:0]                     w_y_reg, w_s_reg, p1_y_reg, p1_s_reg;
    logic                              neg_y_reg, neg_s_reg;
    rk4s_pkg::out_item_t               out_reg;
    logic                              out_valid_reg;

    logic signed [DW-1:0]              h_s, hh_s, mul_a, mul_b, prod_rnd;
    logic signed [AW-1:0]              ky_ext, ks_ext, mag_y, mag_s;
    logic signed [DW-1:0]              y_new, s_new;

    function automatic logic signed [DW-1:0] apply_q(input logic signed [DW-1:0] base,
                                                     input logic [QW-1:0] q,
                                                     input logic neg);
        logic signed [DW+1:0] d;
        logic signed [DW+1:0] sum;
        d   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        sum = $signed({{2{base[DW-1]}}, base}) + d;
        if (sum > $signed({3'b000, {(DW-1){1'b1}}})) begin
            apply_q = {1'b0, {(DW-1){1'b1}}};
        end else if (sum < $signed({3'b111, {(DW-1){1'b0}}})) begin
            apply_q = {1'b1, {(DW-1){1'b0}}};
        end else begin
            apply_q = sum[DW-1:0];
        end
    endfunction

    assign h_s      = $signed({{(DW-rk4s_pkg::STEP_W){1'b0}}, h_reg});
    assign hh_s     = h_s >>> 1;
    assign prod_rnd = rk4s_pkg::rnd_sat(prod_reg);
    assign ky_ext   = $signed({{(AW-DW){ky_reg[DW-1]}}, ky_reg});
    assign ks_ext   = $signed({{(AW-DW){ks_reg[DW-1]}}, ks_reg});
    // (|v| + 5) >> 1 = n + 1 with n = (|v| + 3) >> 1, so (n + 1) * (4^18 - 1) / 3 >> 36 = n / 3
    assign mag_y    = (acc_y_reg < 0 ? -acc_y_reg : acc_y_reg) + AW'(5);
    assign mag_s    = (acc_s_reg < 0 ? -acc_s_reg : acc_s_reg) + AW'(5);
    assign y_new    = apply_q(y_reg, w_y_reg[RS +: QW], neg_y_reg);
    assign s_new    = apply_q(s_reg, w_s_reg[RS +: QW], neg_s_reg);

    always_comb begin
        mul_a = h_s;
        mul_b = ts_reg;
        unique case (cmd.op)
            rk4s_pkg::OP_MUL_F:  mul_a = xc_reg;
            rk4s_pkg::OP_MUL_KS: mul_b = f_reg;
            default: begin
                mul_a = h_s;
                mul_b = ts_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg         <= rk4s_pkg::STEP_RESET;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            s_reg         <= '0;
        end else begin
            if (cfg_valid) begin
                h_reg <= cfg_data;
            end
            if (cmd.op == rk4s_pkg::OP_COMMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == rk4s_pkg::OP_LOAD) begin
                x_reg <= s_data.x_start;
                y_reg <= s_data.y_start;
                s_reg <= s_data.slope_start;
            end else if (cmd.op == rk4s_pkg::OP_COMMIT) begin
                x_reg <= xe_reg;
                y_reg <= y_new;
                s_reg <= s_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.op)
            rk4s_pkg::OP_PREP: begin
                xm_reg    <= rk4s_pkg::sat_add(x_reg, hh_s);
                xe_reg    <= rk4s_pkg::sat_add(x_reg, h_s);
                xc_reg    <= x_reg;
                ty_reg    <= y_reg;
                ts_reg    <= s_reg;
                acc_y_reg <= '0;
                acc_s_reg <= '0;
            end
            rk4s_pkg::OP_WB_KY: ky_reg <= prod_rnd;
            rk4s_pkg::OP_WB_F:  f_reg  <= rk4s_pkg::sat_add(prod_rnd, ty_reg);
            rk4s_pkg::OP_WB_KS: ks_reg <= prod_rnd;
            rk4s_pkg::OP_UPD: begin
                // weights 1, 2, 2, 1 over the four stages
                if (cmd.stage == 2'd0 || cmd.stage == rk4s_pkg::STAGE_LAST) begin
                    acc_y_reg <= acc_y_reg + ky_ext;
                    acc_s_reg <= acc_s_reg + ks_ext;
                end else begin
                    acc_y_reg <= acc_y_reg + (ky_ext <<< 1);
                    acc_s_reg <= acc_s_reg + (ks_ext <<< 1);
                end
                if (cmd.stage == 2'd0 || cmd.stage == 2'd1) begin
                    ty_reg <= rk4s_pkg::sat_add(y_reg, ky_reg >>> 1);
                    ts_reg <= rk4s_pkg::sat_add(s_reg, ks_reg >>> 1);
                    xc_reg <= xm_reg;
                end else if (cmd.stage == 2'd2) begin
                    ty_reg <= rk4s_pkg::sat_add(y_reg, ky_reg);
                    ts_reg <= rk4s_pkg::sat_add(s_reg, ks_reg);
                    xc_reg <= xe_reg;
                end
            end
            rk4s_pkg::OP_DIV_INIT: begin
                // divide the magnitude, then restore the sign: rounds halves away from zero
                neg_y_reg <= acc_y_reg < 0;
                neg_s_reg <= acc_s_reg < 0;
                w_y_reg   <= RW'(mag_y[AW-1:1]);
                w_s_reg   <= RW'(mag_s[AW-1:1]);
            end
            rk4s_pkg::OP_DIV: begin
                // build a * 0x5_5555_5555 from doubling sums of 4^i terms
                unique case (cmd.div_step)
                    3'd0: begin
                        w_y_reg  <= w_y_reg + (w_y_reg << 2);
                        w_s_reg  <= w_s_reg + (w_s_reg << 2);
                        p1_y_reg <= w_y_reg + (w_y_reg << 2);
                        p1_s_reg <= w_s_reg + (w_s_reg << 2);
                    end
                    3'd1: begin
                        w_y_reg <= w_y_reg + (w_y_reg << 4);
                        w_s_reg <= w_s_reg + (w_s_reg << 4);
                    end
                    3'd2: begin
                        w_y_reg <= w_y_reg + (w_y_reg << 8);
                        w_s_reg <= w_s_reg + (w_s_reg << 8);
                    end
                    3'd3: begin
                        w_y_reg <= w_y_reg + (w_y_reg << 16);
                        w_s_reg <= w_s_reg + (w_s_reg << 16);
                    end
                    default: begin
                        w_y_reg <= (w_y_reg << 4) + p1_y_reg;
                        w_s_reg <= (w_s_reg << 4) + p1_s_reg;
                    end
                endcase
            end
            rk4s_pkg::OP_COMMIT: begin
                out_reg.x_now       <= xe_reg;
                out_reg.y_value     <= y_new;
                out_reg.slope_value <= s_new;
                out_reg.last_step   <= cmd.last;
            end
            default: begin
            end
        endcase
    end

    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;
    assign status.out_full = out_valid_reg;

    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == rk4s_pkg::OP_COMMIT |-> !out_valid_reg || m_ready)
        else $error("result overwritten before transaction");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == rk4s_pkg::OP_COMMIT |=> out_valid_reg)
        else $error("committed result not presented");

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == rk4s_pkg::OP_COMMIT |->
            w_y_reg[RW-1:RS+QW] == '0 && w_s_reg[RW-1:RS+QW] == '0)
        else $error("divider quotient out of range");

endmodule

// ===== sv/rk4_second_order_ode_stepper.sv =====
// RK4 stepper for y'' = x*y' + y: sequencer plus shared-multiplier datapath.
// Each step leaves one result in the output register, and a new input is taken only after
// the last step of the previous one; a full output register holds the commit until it drains.
// Per step: a setup state, 4 stages of multiply, write-back and update states on the one 32x32
// multiplier, a divide setup, 5 shift-add steps for the divide by 6 and a commit.
// Reset (aresetn low, synchronous) clears control and state and sets h to 0.1.
module rk4_second_order_ode_stepper (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rk4s_pkg::STEP_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rk4s_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rk4s_pkg::out_item_t         m_data
);

    rk4s_pkg::dp_cmd_t    cmd;
    rk4s_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    rk4s_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .step_count (s_data.step_count),
        .m_ready    (m_ready),
        .status     (status),
        .cmd        (cmd)
    );

    rk4s_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
